// ----- hdl/prl_pkg.sv -----
package prl_pkg;

    // one-hot sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_LK1   = 5'b01000,
        ST_LK2   = 5'b10000
    } state_t;

    // command codes of the input transaction
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic load_en;
        logic look_en;
    } cell_ctrl_t;

endpackage

// ----- hdl/palette_reverse_lookup_core.sv -----
// Palette reverse lookup. After reset the colormap RAM is cleared to zero
// by a clearing pass, with in_ready low, so that a first load of any entry sees
// its old value as zero. A load transaction (cmd 0) writes one colormap
// entry: the colormap RAM read of the old value is registered, then the chain
// of NUM_COLORS cells removes the old entry and inserts the new one in stable
// ascending order. A lookup transaction (cmd 1) registers the pixel, then
// every cell compares it in parallel with the first LINEAR_PROBE indices
// checked for exact match, and the matching position is selected into the
// result register, waiting while that register is still full.
// Loads never produce a result. All entries must be loaded before the first
// lookup. Loads with entry_index >= NUM_COLORS are dropped.
module palette_reverse_lookup_core
    import prl_pkg::*;
#(
    parameter int NUM_COLORS   = 256,
    parameter int LINEAR_PROBE = 8,
    parameter int PIXEL_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  entry_index,
    input  logic [31:0] pixel_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  color_index
);

    localparam int IW = $clog2(NUM_COLORS);
    localparam int PW = PIXEL_BITS;
    localparam int N  = NUM_COLORS;

    state_t        state_reg, state_next;
    logic [PW-1:0] v_reg;
    logic [IW-1:0] k_reg;
    logic [IW-1:0] clr_cnt_reg;
    logic          out_valid_reg;
    logic [7:0]    color_reg;
    logic          probe_hit_reg;
    logic [IW-1:0] probe_idx_reg;
    logic [PW-1:0] old_val;
    cell_ctrl_t    ctrl;
    logic          in_acc;
    logic          in_range;
    logic          out_free;
    logic          clearing;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [PW-1:0] ram_wdata;

    logic [PW-1:0] c_val   [N];
    logic [IW-1:0] c_idx   [N];
    logic          c_lt    [N];
    logic          c_gt    [N];
    logic          c_b     [N];
    logic          c_le    [N];
    logic [N-1:0]  c_sel;
    logic [IW-1:0] c_sidx  [N];
    logic [IW-1:0] sel_or;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign in_range = ({24'd0, entry_index} < 32'(NUM_COLORS));
    assign out_free = !out_valid_reg || out_ready;
    assign clearing = (state_reg == ST_CLEAR);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == IW'(N - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (cmd == CMD_LOOKUP)
                    begin
                        state_next = ST_LK1;
                    end
                    else if (in_range)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: state_next = ST_IDLE;
            ST_LK1:  state_next = ST_LK2;
            ST_LK2:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // clearing pass address after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (clearing)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // capture the transaction payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            v_reg <= PW'(pixel_value);
            k_reg <= IW'(entry_index);
        end
    end

    assign ctrl.load_en = (state_reg == ST_LOAD);
    assign ctrl.look_en = (state_reg == ST_LK1);

    // colormap write: zero fill after reset, then loads
    assign ram_we    = ctrl.load_en || clearing;
    assign ram_waddr = clearing ? clr_cnt_reg : k_reg;
    assign ram_wdata = clearing ? '0 : v_reg;

    // colormap by index, read for the value being replaced
    prl_ram #(
        .WIDTH(PW),
        .DEPTH(N)
    ) u_cmap (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(IW'(entry_index)),
        .rdata(old_val)
    );

    // exact-match probe over the lowest indices
    if (LINEAR_PROBE > 0)
    begin : g_probe
        logic [PW-1:0] probe_val_reg [LINEAR_PROBE];

        always_ff @(posedge clk)
        begin
            for (int p = 0; p < LINEAR_PROBE; p++)
            begin
                if (ctrl.load_en && (k_reg == IW'(p)))
                begin
                    probe_val_reg[p] <= v_reg;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.look_en)
            begin
                probe_hit_reg <= 1'b0;
                probe_idx_reg <= '0;
                for (int p = LINEAR_PROBE - 1; p >= 0; p--)
                begin
                    if (probe_val_reg[p] == v_reg)
                    begin
                        probe_hit_reg <= 1'b1;
                        probe_idx_reg <= IW'(p);
                    end
                end
            end
        end
    end
    else
    begin : g_noprobe
        assign probe_hit_reg = 1'b0;
        assign probe_idx_reg = '0;
    end

    // chain of sorted cells
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [PW-1:0] pv;
        logic [IW-1:0] pi;
        logic          plt;
        logic          pb;
        logic [PW-1:0] nv;
        logic [IW-1:0] ni;
        logic          ngt;
        logic          nb;
        logic          nle;

        if (i == 0)
        begin : g_first
            assign pv  = '0;
            assign pi  = '0;
            assign plt = 1'b0;
            assign pb  = 1'b0;
        end
        else
        begin : g_mid_l
            assign pv  = c_val[i-1];
            assign pi  = c_idx[i-1];
            assign plt = c_lt[i-1];
            assign pb  = c_b[i-1];
        end

        if (i == N - 1)
        begin : g_last
            assign nv  = '0;
            assign ni  = '0;
            assign ngt = 1'b0;
            assign nb  = 1'b0;
            assign nle = 1'b0;
        end
        else
        begin : g_mid_r
            assign nv  = c_val[i+1];
            assign ni  = c_idx[i+1];
            assign ngt = c_gt[i+1];
            assign nb  = c_b[i+1];
            assign nle = c_le[i+1];
        end

        prl_cell #(
            .PW (PW),
            .IW (IW),
            .POS(i),
            .LP (LINEAR_PROBE)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .new_val  (v_reg),
            .new_idx  (k_reg),
            .old_val  (old_val),
            .prev_val (pv),
            .prev_idx (pi),
            .prev_lt_r(plt),
            .prev_b   (pb),
            .next_val (nv),
            .next_idx (ni),
            .next_gt_r(ngt),
            .next_b   (nb),
            .next_le  (nle),
            .val      (c_val[i]),
            .idx      (c_idx[i]),
            .lt_r     (c_lt[i]),
            .gt_r     (c_gt[i]),
            .b        (c_b[i]),
            .le       (c_le[i]),
            .sel      (c_sel[i]),
            .sel_idx  (c_sidx[i])
        );
    end

    // gather the single selected index
    always_comb
    begin
        sel_or = '0;
        for (int i = 0; i < N; i++)
        begin
            sel_or = sel_or | c_sidx[i];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_LK2) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_LK2) && out_free)
        begin
            color_reg <= probe_hit_reg ? 8'(probe_idx_reg) : 8'(sel_or);
        end
    end

    assign out_valid   = out_valid_reg;
    assign color_index = color_reg;

`ifndef SYNTHESIS
    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> (state_reg == ST_IDLE))
        else $error("load update did not finish in one cycle");

    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LK2))
        else $error("result raised outside a lookup");

    a_single_select: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LK2) |-> $onehot(c_sel))
        else $error("sorted chain selected other than one cell");
`endif

endmodule

// ----- hdl/prl_ram.sv -----
module prl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/prl_cell.sv -----
module prl_cell
    import prl_pkg::*;
#(
    parameter int PW  = 32,
    parameter int IW  = 8,
    parameter int POS = 0,
    parameter int LP  = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cell_ctrl_t    ctrl,
    input  logic [PW-1:0] new_val,
    input  logic [IW-1:0] new_idx,
    input  logic [PW-1:0] old_val,
    // left neighbor
    input  logic [PW-1:0] prev_val,
    input  logic [IW-1:0] prev_idx,
    input  logic          prev_lt_r,
    input  logic          prev_b,
    // right neighbor
    input  logic [PW-1:0] next_val,
    input  logic [IW-1:0] next_idx,
    input  logic          next_gt_r,
    input  logic          next_b,
    input  logic          next_le,
    // own entry and flags to neighbors
    output logic [PW-1:0] val,
    output logic [IW-1:0] idx,
    output logic          lt_r,
    output logic          gt_r,
    output logic          b,
    output logic          le,
    output logic          sel,
    output logic [IW-1:0] sel_idx
);

    logic [PW-1:0] val_reg;
    logic [IW-1:0] idx_reg;
    logic          le_reg;
    logic          match;
    logic          keep;
    logic          take_next;
    logic          take_prev;

    // order flags against the removed entry and the inserted entry
    assign match = (idx_reg == new_idx);
    assign lt_r  = (val_reg < old_val) || ((val_reg == old_val) && (idx_reg < new_idx));
    assign gt_r  = !lt_r && !match;
    assign b     = (val_reg < new_val) || ((val_reg == new_val) && (idx_reg < new_idx));

    assign take_next = next_gt_r && next_b;
    assign keep      = !match && (gt_r != b);
    assign take_prev = prev_lt_r && !prev_b;

    // entry update: shift from a neighbor, hold, or take the new entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
            idx_reg <= IW'(POS);
        end
        else if (ctrl.load_en)
        begin
            if (take_next)
            begin
                val_reg <= next_val;
                idx_reg <= next_idx;
            end
            else if (keep)
            begin
                val_reg <= val_reg;
                idx_reg <= idx_reg;
            end
            else if (take_prev)
            begin
                val_reg <= prev_val;
                idx_reg <= prev_idx;
            end
            else
            begin
                val_reg <= new_val;
                idx_reg <= new_idx;
            end
        end
    end

    // compare against the broadcast pixel
    always_ff @(posedge clk)
    begin
        if (ctrl.look_en)
        begin
            le_reg <= (val_reg <= new_val);
        end
    end

    assign val = val_reg;
    assign idx = idx_reg;
    assign le  = le_reg;

    // last searched position whose value does not exceed the pixel, or the first searched position if none does
    always_comb
    begin
        if (POS < LP)
        begin
            sel = 1'b0;
        end
        else if (POS == LP)
        begin
            sel = !le_reg || !next_le;
        end
        else
        begin
            sel = le_reg && !next_le;
        end
    end

    assign sel_idx = sel ? idx_reg : '0;

endmodule

// ----- sim/palette_lookup_checker.sv -----
module palette_lookup_checker
    import prl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  entry_index,
    input  logic [31:0] pixel_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  color_index,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOL  = 256;
    localparam int PROBE = 8;

    logic [31:0] palette [NCOL];
    logic [7:0]  rank_order [NCOL];
    logic [7:0]  expected_index_q [$];

    // stable ascending order of the palette
    function automatic void reorder_palette();
        int rank;
        for (int i = 0; i < NCOL; i++)
        begin
            rank = 0;
            for (int j = 0; j < NCOL; j++)
                if (palette[j] < palette[i] || (palette[j] == palette[i] && j < i))
                    rank++;
            rank_order[rank] = i[7:0];
        end
    endfunction

    // exact probe on low indices, else floor search over sorted tail
    function automatic logic [7:0] reverse_lookup(logic [31:0] pix);
        int best;
        best = PROBE;
        for (int p = 0; p < PROBE; p++)
            if (palette[p] == pix)
                return p[7:0];
        for (int p = PROBE; p < NCOL; p++)
            if (palette[rank_order[p]] <= pix)
                best = p;
        return rank_order[best];
    endfunction

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        for (int i = 0; i < NCOL; i++)
        begin
            palette[i] = '0;
            rank_order[i] = i[7:0];
        end
    end

    // input transactions
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            if (cmd == CMD_LOAD)
            begin
                palette[entry_index] = pixel_value;
                reorder_palette();
            end
            else
                expected_index_q.push_back(reverse_lookup(pixel_value));
        end
        pending_count = expected_index_q.size();
    end

    // result transactions
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_index_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, color_index);
                fail_count++;
            end
            else
            begin
                if (color_index !== expected_index_q[0])
                begin
                    $display("%0t: color_index mismatch, expected %0d, actual %0d",
                             $time, expected_index_q[0], color_index);
                    fail_count++;
                end
                void'(expected_index_q.pop_front());
            end
        end
        pending_count = expected_index_q.size();
    end
endmodule

// ----- sim/palette_reverse_lookup_core_tb.sv -----
module palette_reverse_lookup_core_tb
    import prl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [7:0]  entry_index;
    logic [31:0] pixel_value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  color_index;
    int          fail_count;
    int          pending_count;
    int          cycle_count;
    bit          hold_off;
    logic [31:0] loaded_values [$];

    palette_reverse_lookup_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .entry_index(entry_index), .pixel_value(pixel_value),
        .out_valid(out_valid), .out_ready(out_ready), .color_index(color_index)
    );

    palette_lookup_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .entry_index(entry_index), .pixel_value(pixel_value),
        .out_valid(out_valid), .out_ready(out_ready), .color_index(color_index),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // send one transaction after a random gap, entered at a falling edge
    task automatic send_item(logic c, logic [7:0] idx, logic [31:0] pix);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        entry_index <= idx;
        pixel_value <= pix;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic load_entry(logic [7:0] idx, logic [31:0] pix);
        send_item(CMD_LOAD, idx, pix);
        loaded_values.push_back(pix);
    endtask

    // pixel near a loaded value, or fully random
    function automatic logic [31:0] pick_pixel();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = loaded_values[$urandom_range(0, loaded_values.size() - 1)];
            2: v = loaded_values[$urandom_range(0, loaded_values.size() - 1)] + 1;
            default: v = loaded_values[$urandom_range(0, loaded_values.size() - 1)] - 1;
        endcase
        return v;
    endfunction

    // receiver with random stalls and one long hold-off
    initial
    begin
        int wait_cycles;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else if (out_ready && !out_valid)
                out_ready <= 1'b1;
            else
            begin
                wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
                if (wait_cycles == 0)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    repeat (wait_cycles - 1) @(negedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        int long_stall;
        @(posedge rst_n);
        wait (loaded_values.size() >= 300);
        hold_off = 1'b1;
        long_stall = 0;
        while (long_stall < 300)
        begin
            @(posedge clk);
            long_stall++;
        end
        hold_off = 1'b0;
    end

    // stimulus
    initial
    begin
        int settle;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_LOAD;
        entry_index  = '0;
        pixel_value  = '0;
        cycle_count  = 0;
        hold_off     = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill every entry; duplicates and extremes included
        for (int i = 0; i < 256; i++)
        begin
            if (i == 3 || i == 200)
                load_entry(i[7:0], 32'hFFFF_FFFF);
            else if (i == 5 || i == 100)
                load_entry(i[7:0], 32'h0000_1000);
            else if (i == 255)
                load_entry(i[7:0], 32'h0000_0010);
            else
                load_entry(i[7:0], $urandom);
        end

        // directed lookups: exact probe hit, duplicates, extremes, below all
        send_item(CMD_LOOKUP, 8'hFF, 32'hFFFF_FFFF);
        send_item(CMD_LOOKUP, 8'h00, 32'h0000_1000);
        send_item(CMD_LOOKUP, 8'h00, 32'h0000_0000);
        send_item(CMD_LOOKUP, 8'hA5, 32'h0000_000F);
        send_item(CMD_LOOKUP, 8'h00, 32'h0000_0010);
        send_item(CMD_LOOKUP, 8'h00, 32'hFFFF_FFFE);
        send_item(CMD_LOOKUP, 8'h00, 32'h8000_0000);
        load_entry(8'd255, 32'h0000_0000);
        send_item(CMD_LOOKUP, 8'h00, 32'h0000_0000);
        send_item(CMD_LOOKUP, 8'h00, 32'h7FFF_FFFF);

        // random mix of loads and lookups
        for (int n = 0; n < 440; n++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    load_entry(8'($urandom_range(0, 255)), $urandom);
                else
                    load_entry(8'($urandom_range(0, 255)), pick_pixel());
            end
            else
                send_item(CMD_LOOKUP, 8'($urandom_range(0, 255)), pick_pixel());
        end
        in_valid <= 1'b0;

        // drain and settle
        while (pending_count != 0)
            @(posedge clk);
        settle = 0;
        while (settle < 20)
        begin
            @(posedge clk);
            settle++;
        end
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- palette_reverse_lookup_core.f -----
hdl/prl_pkg.sv
hdl/prl_ram.sv
hdl/prl_cell.sv
hdl/palette_reverse_lookup_core.sv
sim/palette_lookup_checker.sv
sim/palette_reverse_lookup_core_tb.sv
